FILE: rtl/least_wait_job_slot_dispatcher_core_defines.svh
// Assertion macros used by the dispatcher checker.
`ifndef LEAST_WAIT_JOB_SLOT_DISPATCHER_CORE_DEFINES_SVH
`define LEAST_WAIT_JOB_SLOT_DISPATCHER_CORE_DEFINES_SVH

// Same-cycle implication.
`define LWD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lwd_pkg.sv
package lwd_pkg;

  localparam int WORKERS  = 4;
  localparam int SLOTS    = 8;
  localparam int WORKER_W = $clog2(WORKERS);
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int IDX_W    = WORKER_W + SLOT_W;
  localparam int ENTRIES  = WORKERS * SLOTS;
  localparam int CNT_W    = $clog2(SLOTS + 1);

  localparam int UNIT_W  = 24;
  localparam int TAG_W   = 16;
  localparam int SLICE_W = 27;
  localparam int WAIT_W  = SLICE_W + SLOT_W;

  localparam int                ZERO_SLICE_WAIT = 999;
  localparam logic [UNIT_W-1:0] UNIT_RESET      = 24'd1000000;

  // item kinds
  localparam logic [1:0] KIND_SUBMIT = 2'd0;
  localparam logic [1:0] KIND_NEXT   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_DONE_ERR = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       worker;
    logic [1:0]       priority_req;
    logic [TAG_W-1:0] job_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         queue_out;
    logic [2:0]         slot_out;
    logic [TAG_W-1:0]   tag_out;
    logic [SLICE_W-1:0] slice_out;
  } out_item_t;

  // priority to slice factor
  function automatic logic [2:0] prio_factor(input logic [1:0] prio);
    logic [2:0] f;
    case (prio)
      2'd1:    f = 3'd6;
      2'd2:    f = 3'd4;
      2'd3:    f = 3'd2;
      default: f = 3'd0;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/least_wait_job_slot_dispatcher_core.sv
// Least-wait job slot dispatcher: WORKERS queues of SLOTS slots, one result per item.
// Submit: the wait sums walk all 32 slots through the single read port of the tag/slice store,
//   a read state and an accumulate state per slot plus one compare state per queue.
// Next: one head step a cycle, up to a full lap. Done: the head slot is checked and freed. One item at a time.
// Reset (async, active low): all slots free, heads and counts zero, time_unit 1000000;
//   the tag/slice store is not cleared, no clearing pass.
module least_wait_job_slot_dispatcher_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [lwd_pkg::UNIT_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  lwd_pkg::in_item_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output lwd_pkg::out_item_t       out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SUM_RD, S_SUM_ACC, S_SUM_CMP, S_PLACE, S_NEXT, S_DONE, S_EMIT
  } state_e;

  localparam int MW = lwd_pkg::TAG_W + lwd_pkg::SLICE_W;

  state_e                          state_q;
  logic [lwd_pkg::UNIT_W-1:0]      time_unit_q;
  logic [lwd_pkg::ENTRIES-1:0]     busy_q;
  logic [lwd_pkg::SLOT_W-1:0]      head_q [lwd_pkg::WORKERS];
  logic [lwd_pkg::CNT_W-1:0]       cnt_q  [lwd_pkg::WORKERS];

  // per-item working registers
  logic [lwd_pkg::WORKER_W-1:0]    worker_q;
  logic [lwd_pkg::TAG_W-1:0]       tag_q;
  logic [lwd_pkg::SLICE_W-1:0]     slice_q;
  logic [lwd_pkg::WORKER_W-1:0]    q_cnt_q;
  logic [lwd_pkg::SLOT_W-1:0]      s_cnt_q;   // slot in wait sum, step count in next walk
  logic [lwd_pkg::WAIT_W-1:0]      acc_q;
  logic [lwd_pkg::WAIT_W-1:0]      best_wait_q;
  logic [lwd_pkg::WORKER_W-1:0]    best_q;
  logic                            found_q;

  // staged result
  logic [1:0]                      res_status_q;
  logic [1:0]                      res_queue_q;
  logic [2:0]                      res_slot_q;
  logic                            use_rd_q;  // tag/slice come from the store read

  logic                            out_valid_q;
  lwd_pkg::out_item_t              out_q;

  // tag/slice store, one read and one write port
  logic [MW-1:0]                   mem_q [lwd_pkg::ENTRIES];
  logic [MW-1:0]                   rd_data_q;
  logic                            mem_re;
  logic [lwd_pkg::IDX_W-1:0]       mem_raddr;
  logic                            mem_we;
  logic [lwd_pkg::IDX_W-1:0]       mem_waddr;

  logic                            in_accept;
  logic                            worker_ok;
  logic [lwd_pkg::SLICE_W-1:0]     slice_new;
  logic [lwd_pkg::SLOT_W-1:0]      head_cur;
  logic [lwd_pkg::SLOT_W-1:0]      head_nxt;
  logic [lwd_pkg::IDX_W-1:0]       idx_head;
  logic [lwd_pkg::IDX_W-1:0]       idx_next;
  logic [lwd_pkg::IDX_W-1:0]       idx_sum;
  logic [lwd_pkg::SLOTS-1:0]       best_row;
  logic [lwd_pkg::SLOT_W-1:0]      free_slot;
  logic [lwd_pkg::SLICE_W-1:0]     rd_slice;
  logic [lwd_pkg::TAG_W-1:0]       rd_tag;
  logic [lwd_pkg::WAIT_W-1:0]      acc_d;
  logic                            queue_open;
  lwd_pkg::out_item_t              out_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // worker index range check (kept for other queue counts)
  assign worker_ok = (int'(in_data_i.worker) < lwd_pkg::WORKERS);

  // slice = factor * unit, factor in {0,6,4,2}
  assign slice_new = lwd_pkg::SLICE_W'(lwd_pkg::prio_factor(in_data_i.priority_req))
                   * lwd_pkg::SLICE_W'(time_unit_q);

  assign head_cur = head_q[worker_q];
  assign head_nxt = (head_cur == lwd_pkg::SLOT_W'(lwd_pkg::SLOTS - 1)) ? '0
                  : head_cur + 1'b1;
  assign idx_head = {worker_q, head_cur};
  assign idx_next = {worker_q, head_nxt};
  assign idx_sum  = {q_cnt_q, s_cnt_q};

  assign rd_slice = rd_data_q[lwd_pkg::SLICE_W-1:0];
  assign rd_tag   = rd_data_q[MW-1:lwd_pkg::SLICE_W];

  // wait contribution of the slot read last cycle; a zero slice weighs 999
  always_comb begin
    acc_d = acc_q;
    if (busy_q[idx_sum]) begin
      if (rd_slice == '0) begin
        acc_d = acc_q + lwd_pkg::WAIT_W'(lwd_pkg::ZERO_SLICE_WAIT);
      end else begin
        acc_d = acc_q + lwd_pkg::WAIT_W'(rd_slice);
      end
    end
  end

  assign queue_open = (cnt_q[q_cnt_q] != lwd_pkg::CNT_W'(lwd_pkg::SLOTS));

  // lowest free slot of the chosen queue
  assign best_row = busy_q[{best_q, {lwd_pkg::SLOT_W{1'b0}}} +: lwd_pkg::SLOTS];
  always_comb begin
    free_slot = '0;
    for (int i = lwd_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!best_row[i]) free_slot = lwd_pkg::SLOT_W'(i);
    end
  end

  // store port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_sum;
    case (state_q)
      S_SUM_RD: mem_re = 1'b1;
      S_NEXT: begin
        mem_re    = busy_q[idx_next];
        mem_raddr = idx_next;
      end
      S_DONE: begin
        mem_re    = busy_q[idx_head];
        mem_raddr = idx_head;
      end
      default: mem_re = 1'b0;
    endcase
  end

  assign mem_we    = (state_q == S_PLACE) && found_q;
  assign mem_waddr = {best_q, free_slot};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= {tag_q, slice_q};
    if (mem_re) rd_data_q <= mem_q[mem_raddr];
  end

  always_comb begin
    out_d.status    = res_status_q;
    out_d.queue_out = res_queue_q;
    out_d.slot_out  = res_slot_q;
    out_d.tag_out   = use_rd_q ? rd_tag : tag_q;
    out_d.slice_out = use_rd_q ? rd_slice : slice_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      time_unit_q  <= lwd_pkg::UNIT_RESET;
      busy_q       <= '0;
      for (int w = 0; w < lwd_pkg::WORKERS; w++) begin
        head_q[w] <= '0;
        cnt_q[w]  <= '0;
      end
      worker_q     <= '0;
      tag_q        <= '0;
      slice_q      <= '0;
      q_cnt_q      <= '0;
      s_cnt_q      <= '0;
      acc_q        <= '0;
      best_wait_q  <= '0;
      best_q       <= '0;
      found_q      <= 1'b0;
      res_status_q <= lwd_pkg::ST_OK;
      res_queue_q  <= '0;
      res_slot_q   <= '0;
      use_rd_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) time_unit_q <= cfg_wdata_i;
      // in S_EMIT the emit branch below owns out_valid_q
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            worker_q    <= in_data_i.worker;
            tag_q       <= in_data_i.job_tag;
            slice_q     <= slice_new;
            res_queue_q <= in_data_i.worker;
            res_slot_q  <= '0;
            use_rd_q    <= 1'b0;
            q_cnt_q     <= '0;
            s_cnt_q     <= '0;
            acc_q       <= '0;
            found_q     <= 1'b0;
            best_q      <= '0;
            best_wait_q <= '0;
            case (in_data_i.kind)
              lwd_pkg::KIND_SUBMIT: state_q <= S_SUM_RD;
              lwd_pkg::KIND_NEXT, lwd_pkg::KIND_DONE: begin
                if (worker_ok) begin
                  state_q <= (in_data_i.kind == lwd_pkg::KIND_NEXT) ? S_NEXT : S_DONE;
                end else begin
                  res_status_q <= lwd_pkg::ST_NONE;
                  tag_q        <= '0;
                  slice_q      <= '0;
                  state_q      <= S_EMIT;
                end
              end
              default: begin
                res_status_q <= lwd_pkg::ST_NONE;
                res_queue_q  <= '0;
                tag_q        <= '0;
                slice_q      <= '0;
                state_q      <= S_EMIT;
              end
            endcase
          end
        end

        S_SUM_RD: state_q <= S_SUM_ACC;

        S_SUM_ACC: begin
          acc_q <= acc_d;
          if (s_cnt_q == lwd_pkg::SLOT_W'(lwd_pkg::SLOTS - 1)) begin
            s_cnt_q <= '0;
            state_q <= S_SUM_CMP;
          end else begin
            s_cnt_q <= s_cnt_q + 1'b1;
            state_q <= S_SUM_RD;
          end
        end

        S_SUM_CMP: begin
          // strict less-than: ties keep the lower queue
          if (queue_open && (!found_q || acc_q < best_wait_q)) begin
            found_q     <= 1'b1;
            best_q      <= q_cnt_q;
            best_wait_q <= acc_q;
          end
          acc_q <= '0;
          if (q_cnt_q == lwd_pkg::WORKER_W'(lwd_pkg::WORKERS - 1)) begin
            state_q <= S_PLACE;
          end else begin
            q_cnt_q <= q_cnt_q + 1'b1;
            state_q <= S_SUM_RD;
          end
        end

        S_PLACE: begin
          if (found_q) begin
            busy_q[{best_q, free_slot}] <= 1'b1;
            cnt_q[best_q]               <= cnt_q[best_q] + 1'b1;
            res_status_q                <= lwd_pkg::ST_OK;
            res_queue_q                 <= best_q;
            res_slot_q                  <= free_slot;
          end else begin
            // all queues full
            res_status_q <= lwd_pkg::ST_NONE;
            res_queue_q  <= '0;
            res_slot_q   <= '0;
          end
          state_q <= S_EMIT;
        end

        S_NEXT: begin
          head_q[worker_q] <= head_nxt;
          s_cnt_q          <= s_cnt_q + 1'b1;
          res_slot_q       <= head_nxt;
          if (busy_q[idx_next]) begin
            res_status_q <= lwd_pkg::ST_OK;
            use_rd_q     <= 1'b1;
            state_q      <= S_EMIT;
          end else if (s_cnt_q == lwd_pkg::SLOT_W'(lwd_pkg::SLOTS - 1)) begin
            // full lap, nothing queued
            res_status_q <= lwd_pkg::ST_NONE;
            tag_q        <= '0;
            slice_q      <= '0;
            state_q      <= S_EMIT;
          end
        end

        S_DONE: begin
          res_slot_q <= head_cur;
          if (busy_q[idx_head]) begin
            busy_q[idx_head] <= 1'b0;
            if (cnt_q[worker_q] != '0) cnt_q[worker_q] <= cnt_q[worker_q] - 1'b1;
            res_status_q <= lwd_pkg::ST_OK;
            use_rd_q     <= 1'b1;
          end else begin
            res_status_q <= lwd_pkg::ST_DONE_ERR;
            tag_q        <= '0;
            slice_q      <= '0;
          end
          state_q <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_q       <= out_d;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/lwd_checker.sv
`include "least_wait_job_slot_dispatcher_core_defines.svh"

module lwd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lwd_pkg::out_item_t out_data_o
);

  `LWD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "item accepted but block not busy next cycle")
  `LWD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result dropped or changed")
  `LWD_ASSERT_NOW(a_done_err_empty, clk_i, rst_ni, out_valid_o && out_data_o.status == lwd_pkg::ST_DONE_ERR, out_data_o.tag_out == '0 && out_data_o.slice_out == '0, "done error result carries tag or slice")
  `LWD_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o, out_data_o.status == lwd_pkg::ST_OK || out_data_o.status == lwd_pkg::ST_NONE || out_data_o.status == lwd_pkg::ST_DONE_ERR, "unknown status code")

endmodule

bind least_wait_job_slot_dispatcher_core lwd_checker u_lwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
